/* hw/rtl/fisr_pkg.sv */
// fisr_pkg: shared constants, operand kind codes and binary32 helper functions
// for the fast inverse square root pipeline. Used by fisr_fmul, fisr_fadd and
// fast_inverse_sqrt. No dependencies.
`timescale 1ns / 1ps

package fisr_pkg;

    // Operand/result classification carried down the arithmetic pipelines
    typedef logic [1:0] t_kind;
    localparam t_kind K_NUM  = 2'd0;
    localparam t_kind K_ZERO = 2'd1;
    localparam t_kind K_INF  = 2'd2;
    localparam t_kind K_NAN  = 2'd3;

    localparam logic [31:0] RSQ_MAGIC     = 32'h5F3759DF;
    localparam logic [31:0] F_QNAN        = 32'h7FC00000;
    localparam logic [31:0] F_HALF        = 32'h3F000000;
    localparam logic [31:0] F_THREE_HALF  = 32'h3FC00000;

    // Register stages in each arithmetic unit
    localparam int FMUL_LAT = 4;
    localparam int FADD_LAT = 4;
    localparam int SEED_DLY = 3 * FMUL_LAT + FADD_LAT;

    // Right shift that clears the whole 48-bit product
    localparam logic [5:0] FM_RSH_MAX = 6'd48;
    // Aligned shift that clears the whole 27-bit addend
    localparam logic [7:0] FA_ALN_MAX = 8'd27;

    function automatic logic is_nan(input logic [31:0] f);
        return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] f);
        return (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
    endfunction

    function automatic logic is_zero(input logic [31:0] f);
        return f[30:0] == 31'd0;
    endfunction

    // Leading zero count of a 48-bit word; 48 when the word is zero
    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        n = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) begin
                n = 6'(47 - i);
            end
        end
        return n;
    endfunction

    // Round to nearest even and pack; e is the biased exponent for a
    // mantissa with its leading one at bit 23 (subnormal if bit 23 clear)
    function automatic logic [31:0] round_pack(input logic s, input logic [9:0] e,
                                               input logic [23:0] m, input logic g,
                                               input logic st);
        logic        up;
        logic [24:0] mr;
        logic [9:0]  ex;
        up = g & (st | m[0]);
        mr = {1'b0, m} + 25'(up);
        if (mr[24]) begin
            ex = e + 10'd1;
        end else if (mr[23]) begin
            ex = e;
        end else begin
            ex = 10'd0;
        end
        if (ex >= 10'd255) begin
            return {s, 8'hFF, 23'd0};
        end
        return {s, ex[7:0], mr[22:0]};
    endfunction

    function automatic logic [31:0] pack_special(input t_kind k, input logic s);
        logic [31:0] r;
        case (k)
            K_NAN:   r = F_QNAN;
            K_INF:   r = {s, 8'hFF, 23'd0};
            default: r = {s, 31'd0};
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/fast_inverse_sqrt.sv */
// fast_inverse_sqrt: streaming 1/sqrt(x) on binary32 patterns, magic-constant
// seed and one Newton step. Depends on fisr_pkg, fisr_fmul, fisr_fadd.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------
//   operand | in        | i_valid / o_stall  | i_x_bits [31:0]
//   result  | out       | o_valid / i_stall  | o_y_bits [31:0]
//
// One transaction in and one out per cycle, sustained while neither side stalls.
// The input register loads at the accepting edge, then five 4-stage float units
// run in series (0.5*x, half*y, (half*y)*y, 1.5-hyy, y*corr; the seed is formed
// beside the first), then the output register.
// Reset (synchronous, active low) clears only valid bits; nothing else needs it.
// A stalled result sits in the output register; the next one drops into a skid
// register, and only a full skid freezes the pipeline and raises o_stall.
`timescale 1ns / 1ps

module fast_inverse_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_x_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_y_bits
);

    logic        en;

    // input register
    logic        r_a_v;
    logic [31:0] r_a_x;
    logic [31:0] seed;

    // seed delay line, tapped where each Newton operation needs y
    logic [31:0] r_sd [fisr_pkg::SEED_DLY];

    logic        half_v, hy_v, hyy_v, corr_v, res_v;
    logic [31:0] half_f, hy_f, hyy_f, corr_f, res_f;
    logic [31:0] tail_y;

    // output register and skid
    logic        r_ov, r_sv;
    logic [31:0] r_oy, r_sy;

    // freeze the pipeline only when the skid holds a result
    assign en      = !r_sv;
    assign o_stall = r_sv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_x <= i_x_bits;
        end
    end

    // integer seed: magic minus the arithmetic half of the pattern
    assign seed = fisr_pkg::RSQ_MAGIC - {r_a_x[31], r_a_x[31:1]};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= seed;
            for (int i = 1; i < fisr_pkg::SEED_DLY; i++) begin
                r_sd[i] <= r_sd[i-1];
            end
        end
    end

    fisr_fmul u_half (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_a_v),
        .i_a     (r_a_x),
        .i_b     (fisr_pkg::F_HALF),
        .o_valid (half_v),
        .o_res   (half_f)
    );

    fisr_fmul u_hy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (half_v),
        .i_a     (half_f),
        .i_b     (r_sd[fisr_pkg::FMUL_LAT-1]),
        .o_valid (hy_v),
        .o_res   (hy_f)
    );

    fisr_fmul u_hyy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (hy_v),
        .i_a     (hy_f),
        .i_b     (r_sd[2*fisr_pkg::FMUL_LAT-1]),
        .o_valid (hyy_v),
        .o_res   (hyy_f)
    );

    // 1.5 - hyy as 1.5 + (-hyy)
    fisr_fadd u_corr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (hyy_v),
        .i_a     (fisr_pkg::F_THREE_HALF),
        .i_b     ({~hyy_f[31], hyy_f[30:0]}),
        .o_valid (corr_v),
        .o_res   (corr_f)
    );

    fisr_fmul u_res (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (corr_v),
        .i_a     (r_sd[fisr_pkg::SEED_DLY-1]),
        .i_b     (corr_f),
        .o_valid (res_v),
        .o_res   (res_f)
    );

    // any NaN leaves as the canonical quiet NaN
    assign tail_y = fisr_pkg::is_nan(res_f) ? fisr_pkg::F_QNAN : res_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            // drain the skid into the output register
            if (!i_stall) begin
                r_sv <= 1'b0;
            end
        end else if (!r_ov || !i_stall) begin
            r_ov <= res_v;
        end else if (res_v) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (!i_stall) begin
                r_oy <= r_sy;
            end
        end else if (!r_ov || !i_stall) begin
            r_oy <= tail_y;
        end else begin
            r_sy <= tail_y;
        end
    end

    assign o_valid  = r_ov;
    assign o_y_bits = r_oy;

    // skid only ever holds a result behind a valid output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid full while output register empty");

    // skid fills whenever a result arrives while the output register is held by a stall
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_sv && r_ov && i_stall && res_v) |=> r_sv)
        else $error("result not caught by skid");

    // draining the skid keeps the output valid and empties the skid
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv && !i_stall) |=> (r_ov && !r_sv))
        else $error("skid drain lost a result");

    // frozen pipeline holds its tail
    a_tail_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv && $past(r_sv)) |-> ($stable(res_v) && $stable(res_f)))
        else $error("pipeline tail moved while frozen");

endmodule

/* hw/rtl/fisr_fmul.sv */
// fisr_fmul: four-stage binary32 multiplier, round to nearest even, subnormals kept.
// Depends on fisr_pkg.
`timescale 1ns / 1ps

module fisr_fmul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_valid,
    output logic [31:0] o_res
);

    // stage 1: unpack and multiply
    logic                 r1_v, n1_v;
    logic [47:0]          r1_p, n1_p;
    logic signed [10:0]   r1_e0, n1_e0;
    logic                 r1_s, n1_s;
    fisr_pkg::t_kind      r1_k, n1_k;
    // stage 2: normalize amount
    logic                 r2_v;
    logic [47:0]          r2_p;
    logic                 r2_left, n2_left;
    logic [5:0]           r2_sh, n2_sh;
    logic [9:0]           r2_e, n2_e;
    logic                 r2_s;
    fisr_pkg::t_kind      r2_k;
    // stage 3: shift
    logic                 r3_v;
    logic [47:0]          r3_w, n3_w;
    logic                 r3_st, n3_st;
    logic [9:0]           r3_e;
    logic                 r3_s;
    fisr_pkg::t_kind      r3_k;
    // stage 4: round
    logic                 r4_v;
    logic [31:0]          r4_res, n4_res;

    logic [7:0]           ea, eb;
    logic [23:0]          ma, mb;
    logic [5:0]           lz;
    logic signed [10:0]   em1, rs, et;

    always_comb begin
        ea = (i_a[30:23] == 8'd0) ? 8'd1 : i_a[30:23];
        eb = (i_b[30:23] == 8'd0) ? 8'd1 : i_b[30:23];
        ma = {i_a[30:23] != 8'd0, i_a[22:0]};
        mb = {i_b[30:23] != 8'd0, i_b[22:0]};
        n1_v  = i_valid;
        n1_p  = ma * mb;
        n1_e0 = $signed({3'd0, ea}) + $signed({3'd0, eb}) - 11'sd126;
        n1_s  = i_a[31] ^ i_b[31];
        if (fisr_pkg::is_nan(i_a) || fisr_pkg::is_nan(i_b)
            || (fisr_pkg::is_inf(i_a) && fisr_pkg::is_zero(i_b))
            || (fisr_pkg::is_zero(i_a) && fisr_pkg::is_inf(i_b))) begin
            n1_k = fisr_pkg::K_NAN;
        end else if (fisr_pkg::is_inf(i_a) || fisr_pkg::is_inf(i_b)) begin
            n1_k = fisr_pkg::K_INF;
        end else if (fisr_pkg::is_zero(i_a) || fisr_pkg::is_zero(i_b)) begin
            n1_k = fisr_pkg::K_ZERO;
        end else begin
            n1_k = fisr_pkg::K_NUM;
        end
    end

    always_comb begin
        lz  = fisr_pkg::lzc48(r1_p);
        em1 = r1_e0 - 11'sd1;
        rs  = 11'sd1 - r1_e0;
        et  = 11'sd0;
        if (r1_e0 >= 11'sd1) begin
            n2_left = 1'b1;
            n2_sh   = ($signed({5'd0, lz}) <= em1) ? lz : em1[5:0];
            et      = r1_e0 - $signed({5'd0, n2_sh});
            n2_e    = et[9:0];
        end else begin
            n2_left = 1'b0;
            n2_sh   = (rs >= $signed({5'd0, fisr_pkg::FM_RSH_MAX})) ?
                      fisr_pkg::FM_RSH_MAX : rs[5:0];
            n2_e    = 10'd1;
        end
    end

    always_comb begin
        if (r2_left) begin
            n3_w  = r2_p << r2_sh;
            n3_st = 1'b0;
        end else if (r2_sh == fisr_pkg::FM_RSH_MAX) begin
            n3_w  = 48'd0;
            n3_st = |r2_p;
        end else begin
            n3_w  = r2_p >> r2_sh;
            n3_st = |(r2_p & ~({48{1'b1}} << r2_sh));
        end
    end

    always_comb begin
        if (r3_k == fisr_pkg::K_NUM) begin
            n4_res = fisr_pkg::round_pack(r3_s, r3_e, r3_w[47:24], r3_w[23],
                                          (|r3_w[22:0]) | r3_st);
        end else begin
            n4_res = fisr_pkg::pack_special(r3_k, r3_s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= n1_v;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p    <= n1_p;
            r1_e0   <= n1_e0;
            r1_s    <= n1_s;
            r1_k    <= n1_k;
            r2_p    <= r1_p;
            r2_left <= n2_left;
            r2_sh   <= n2_sh;
            r2_e    <= n2_e;
            r2_s    <= r1_s;
            r2_k    <= r1_k;
            r3_w    <= n3_w;
            r3_st   <= n3_st;
            r3_e    <= r2_e;
            r3_s    <= r2_s;
            r3_k    <= r2_k;
            r4_res  <= n4_res;
        end
    end

    assign o_valid = r4_v;
    assign o_res   = r4_res;

endmodule

/* hw/rtl/fisr_fadd.sv */
// fisr_fadd: four-stage binary32 adder, round to nearest even, subnormals kept.
// Depends on fisr_pkg.
`timescale 1ns / 1ps

module fisr_fadd (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_valid,
    output logic [31:0] o_res
);

    // stage 1: order by magnitude
    logic             r1_v;
    fisr_pkg::t_kind  r1_k, n1_k;
    logic             r1_s, n1_s;
    logic             r1_zs, n1_zs;
    logic             r1_sub, n1_sub;
    logic [7:0]       r1_ea, n1_ea;
    logic [7:0]       r1_d, n1_d;
    logic [23:0]      r1_ma, n1_ma;
    logic [23:0]      r1_mb, n1_mb;
    // stage 2: align and add
    logic             r2_v;
    logic [27:0]      r2_sum, n2_sum;
    logic [7:0]       r2_ea;
    logic             r2_s, r2_zs;
    fisr_pkg::t_kind  r2_k;
    // stage 3: normalize
    logic             r3_v;
    logic [26:0]      r3_w, n3_w;
    logic [9:0]       r3_e, n3_e;
    logic             r3_s, n3_s;
    fisr_pkg::t_kind  r3_k, n3_k;
    // stage 4: round
    logic             r4_v;
    logic [31:0]      r4_res, n4_res;

    logic             swap;
    logic [31:0]      fl, fs;
    logic [7:0]       eb;
    logic [26:0]      mbx, al;
    logic [5:0]       lz;
    logic [7:0]       lim;
    logic [5:0]       sh;

    always_comb begin
        swap   = i_b[30:0] > i_a[30:0];
        fl     = swap ? i_b : i_a;
        fs     = swap ? i_a : i_b;
        n1_ea  = (fl[30:23] == 8'd0) ? 8'd1 : fl[30:23];
        eb     = (fs[30:23] == 8'd0) ? 8'd1 : fs[30:23];
        n1_d   = n1_ea - eb;
        n1_ma  = {fl[30:23] != 8'd0, fl[22:0]};
        n1_mb  = {fs[30:23] != 8'd0, fs[22:0]};
        n1_s   = fl[31];
        n1_sub = i_a[31] ^ i_b[31];
        n1_zs  = i_a[31] & i_b[31];
        if (fisr_pkg::is_nan(i_a) || fisr_pkg::is_nan(i_b)
            || (fisr_pkg::is_inf(i_a) && fisr_pkg::is_inf(i_b) && n1_sub)) begin
            n1_k = fisr_pkg::K_NAN;
        end else if (fisr_pkg::is_inf(i_a) || fisr_pkg::is_inf(i_b)) begin
            n1_k = fisr_pkg::K_INF;
        end else begin
            n1_k = fisr_pkg::K_NUM;
        end
    end

    always_comb begin
        mbx = {r1_mb, 3'd0};
        if (r1_d >= fisr_pkg::FA_ALN_MAX) begin
            al = {26'd0, |r1_mb};
        end else begin
            al = (mbx >> r1_d) | {26'd0, |(mbx & ~({27{1'b1}} << r1_d))};
        end
        if (r1_sub) begin
            n2_sum = {1'b0, r1_ma, 3'd0} - {1'b0, al};
        end else begin
            n2_sum = {1'b0, r1_ma, 3'd0} + {1'b0, al};
        end
    end

    always_comb begin
        lz   = fisr_pkg::lzc48({r2_sum[26:0], 21'd0});
        lim  = r2_ea - 8'd1;
        sh   = ({2'd0, lz} <= lim) ? lz : lim[5:0];
        n3_s = r2_s;
        n3_k = r2_k;
        if (r2_sum[27]) begin
            n3_w = {r2_sum[27:2], r2_sum[1] | r2_sum[0]};
            n3_e = {2'd0, r2_ea} + 10'd1;
        end else begin
            n3_w = r2_sum[26:0] << sh;
            n3_e = {2'd0, r2_ea} - {4'd0, sh};
        end
        if (r2_k == fisr_pkg::K_NUM && r2_sum == 28'd0) begin
            n3_k = fisr_pkg::K_ZERO;
            n3_s = r2_zs;
        end
    end

    always_comb begin
        if (r3_k == fisr_pkg::K_NUM) begin
            n4_res = fisr_pkg::round_pack(r3_s, r3_e, r3_w[26:3], r3_w[2], |r3_w[1:0]);
        end else begin
            n4_res = fisr_pkg::pack_special(r3_k, r3_s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_k   <= n1_k;
            r1_s   <= n1_s;
            r1_zs  <= n1_zs;
            r1_sub <= n1_sub;
            r1_ea  <= n1_ea;
            r1_d   <= n1_d;
            r1_ma  <= n1_ma;
            r1_mb  <= n1_mb;
            r2_sum <= n2_sum;
            r2_ea  <= r1_ea;
            r2_s   <= r1_s;
            r2_zs  <= r1_zs;
            r2_k   <= r1_k;
            r3_w   <= n3_w;
            r3_e   <= n3_e;
            r3_s   <= n3_s;
            r3_k   <= n3_k;
            r4_res <= n4_res;
        end
    end

    assign o_valid = r4_v;
    assign o_res   = r4_res;

endmodule
